FILE: hw/rtl/mpe_pkg.sv
// mpe_pkg: types, constants and the crc helper for the section encapsulator
// used by mpe_front, mpe_back and the top level; depends on nothing else
package mpe_pkg;

  // datagram layout
  localparam int unsigned LEAD_COUNT = 20;
  localparam logic [4:0] SLOT_LAST_LEAD = 5'd19;
  localparam logic [4:0] SLOT_PASS = 5'd20;
  localparam logic [4:0] HDR_LEN = 5'd12;
  localparam logic [4:0] BURST_LAST = 5'd31;
  localparam logic [1:0] CRC_LAST = 2'd3;
  localparam logic [11:0] LEN_MIN = 12'd20;

  // section header constants
  localparam logic [7:0] TABLE_ID = 8'h3e;
  localparam logic [7:0] SLEN_FLAGS = 8'hb0;
  localparam logic [7:0] HDR_FLAGS = 8'hc1;
  localparam logic [7:0] MAC2_MCAST = 8'h5e;
  localparam logic [7:0] MCAST_MASK = 8'he0;
  localparam logic [7:0] MAC3_MASK = 8'h7f;
  localparam logic [7:0] MAC0_MCAST = 8'h01;
  localparam logic [11:0] SEC_OVERHEAD = 12'd13;

  // stuffing: 183 - ((len + 16) mod 184), 184 = 8 * 23
  localparam logic [12:0] FILL_BIAS = 13'd16;
  localparam logic [9:0] INV23 = 10'd713;
  localparam int unsigned INV23_SHIFT = 14;
  localparam logic [4:0] DIV23 = 5'd23;
  localparam logic [7:0] FILL_TOP = 8'd183;

  // crc-32, mpeg-2 flavor
  localparam logic [31:0] CRC_POLY = 32'h04c11db7;
  localparam logic [31:0] CRC_INIT = 32'hffffffff;

  // queue depths
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned RES_DEPTH = 2;

  // classified datagram byte, front to back
  typedef struct packed {
    logic [7:0]  data;
    logic [4:0]  slot;   // lead slot 0..19, or pass-through
    logic        last;
    logic [11:0] len;
    logic [7:0]  fill;
  } cmd_t;

  // one section byte toward the output queue
  typedef struct packed {
    logic [7:0] out_byte;
    logic       section_end;
    logic [7:0] fill_count;
  } res_t;

  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_BURST = 3'b010,
    ST_CRC   = 3'b100
  } back_state_t;

  // msb-first crc over one byte
  function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'd0};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/mpe_fifo.sv
// mpe_fifo: small register queue with push/full and pop/empty sides
// depends on nothing; used for the command queue and the result queue
module mpe_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

FILE: hw/rtl/mpe_front.sv
// mpe_front: counts datagram bytes, samples the length, classifies each byte
// depends on mpe_pkg; feeds the command queue
module mpe_front
  import mpe_pkg::*;
#(
  parameter int unsigned MAX_DATAGRAM = 4080
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic [11:0] datagram_len,
  output cmd_t        cmd
);

  logic [11:0] byte_index;
  logic [11:0] held_length;
  logic [11:0] clamp_len;
  logic [11:0] cur_len;
  logic        first;
  logic        last;
  logic [12:0] fill_x;
  logic [9:0]  fill_y;
  logic [19:0] fill_prod;
  logic [4:0]  fill_q;
  logic [9:0]  fill_r;
  logic [7:0]  fill_mod;

  // length sampled with the first byte, clamped to range
  always_comb begin
    clamp_len = datagram_len;
    if (datagram_len < LEN_MIN) begin
      clamp_len = LEN_MIN;
    end else if (datagram_len > 12'(MAX_DATAGRAM)) begin
      clamp_len = 12'(MAX_DATAGRAM);
    end
  end

  assign first   = (byte_index == '0);
  assign cur_len = first ? clamp_len : held_length;
  assign last    = ({1'b0, byte_index} + 13'd1) >= {1'b0, cur_len};

  // stuffing count: mod 184 as mod 8 and mod 23 by reciprocal
  assign fill_x    = {1'b0, held_length} + FILL_BIAS;
  assign fill_y    = fill_x[12:3];
  assign fill_prod = 20'(fill_y * INV23);
  assign fill_q    = fill_prod[INV23_SHIFT +: 5];
  assign fill_r    = fill_y - 10'(fill_q * DIV23);
  assign fill_mod  = {fill_r[4:0], fill_x[2:0]};

  // classified byte
  always_comb begin
    cmd.data = data_byte;
    cmd.slot = (byte_index < 12'(LEAD_COUNT)) ? byte_index[4:0] : SLOT_PASS;
    cmd.last = last;
    cmd.len  = held_length;
    cmd.fill = FILL_TOP - fill_mod;
  end

  // byte position within the datagram
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      held_length <= '0;
    end else if (accept) begin
      if (first) begin
        held_length <= clamp_len;
      end
      byte_index <= last ? '0 : byte_index + 12'd1;
    end
  end

endmodule

FILE: hw/rtl/mpe_back.sv
// mpe_back: keeps the lead bytes, emits header, datagram and crc bytes
// depends on mpe_pkg; reads the command queue, writes the result queue
module mpe_back
  import mpe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic stuff_enable,
  input  cmd_t cmd,
  input  logic cmd_empty,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  back_state_t state, state_next;
  logic [4:0]  cnt, cnt_next;
  logic [31:0] crc, crc_next;
  logic [7:0]  lead [LEAD_COUNT];
  logic [11:0] sec_len;
  logic        sec_last;
  logic [7:0]  sec_fill;
  logic [11:0] slen;
  logic        mcast;
  logic [4:0]  lead_idx;
  logic [7:0]  burst_byte;
  logic [7:0]  crc_byte;

  assign slen     = sec_len + SEC_OVERHEAD;
  assign mcast    = (lead[16] & MCAST_MASK) == MCAST_MASK;
  assign lead_idx = cnt - HDR_LEN;

  // header bytes, then the held datagram bytes
  always_comb begin
    unique case (cnt)
      5'd0:    burst_byte = TABLE_ID;
      5'd1:    burst_byte = SLEN_FLAGS | {4'd0, slen[11:8]};
      5'd2:    burst_byte = slen[7:0];
      5'd3:    burst_byte = mcast ? lead[19] : 8'd0;
      5'd4:    burst_byte = mcast ? lead[18] : 8'd0;
      5'd5:    burst_byte = HDR_FLAGS;
      5'd6:    burst_byte = 8'd0;
      5'd7:    burst_byte = 8'd0;
      5'd8:    burst_byte = mcast ? (lead[17] & MAC3_MASK) : 8'd0;
      5'd9:    burst_byte = mcast ? MAC2_MCAST : 8'd0;
      5'd10:   burst_byte = 8'd0;
      5'd11:   burst_byte = mcast ? MAC0_MCAST : 8'd0;
      default: burst_byte = lead[lead_idx];
    endcase
  end

  // crc bytes, most significant first
  always_comb begin
    case (cnt[1:0])
      2'd0:    crc_byte = crc[31:24];
      2'd1:    crc_byte = crc[23:16];
      2'd2:    crc_byte = crc[15:8];
      default: crc_byte = crc[7:0];
    endcase
  end

  // sequencer
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    crc_next        = crc;
    cmd_pop         = 1'b0;
    res_push        = 1'b0;
    res.out_byte    = 8'd0;
    res.section_end = 1'b0;
    res.fill_count  = 8'd0;
    unique case (state)
      ST_RUN: begin
        if (!cmd_empty) begin
          if (cmd.slot == SLOT_PASS) begin
            if (!res_full) begin
              cmd_pop      = 1'b1;
              res_push     = 1'b1;
              res.out_byte = cmd.data;
              crc_next     = crc_feed(crc, cmd.data);
              if (cmd.last) begin
                state_next = ST_CRC;
                cnt_next   = '0;
              end
            end
          end else begin
            cmd_pop = 1'b1;
            if (cmd.slot == SLOT_LAST_LEAD) begin
              state_next = ST_BURST;
              cnt_next   = '0;
            end
          end
        end
      end
      ST_BURST: begin
        if (!res_full) begin
          res_push     = 1'b1;
          res.out_byte = burst_byte;
          crc_next     = crc_feed(crc, burst_byte);
          if (cnt == BURST_LAST) begin
            cnt_next   = '0;
            state_next = sec_last ? ST_CRC : ST_RUN;
          end else begin
            cnt_next = cnt + 5'd1;
          end
        end
      end
      ST_CRC: begin
        if (!res_full) begin
          res_push     = 1'b1;
          res.out_byte = crc_byte;
          if (cnt[1:0] == CRC_LAST) begin
            res.section_end = 1'b1;
            res.fill_count  = stuff_enable ? sec_fill : 8'd0;
            crc_next        = CRC_INIT;
            cnt_next        = '0;
            state_next      = ST_RUN;
          end else begin
            cnt_next = cnt + 5'd1;
          end
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      cnt   <= '0;
      crc   <= CRC_INIT;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      crc   <= crc_next;
    end
  end

  // lead bytes and per-section values
  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd.slot != SLOT_PASS)) begin
      lead[cmd.slot] <= cmd.data;
    end
    if (cmd_pop && (cmd.slot == SLOT_LAST_LEAD)) begin
      sec_len  <= cmd.len;
      sec_last <= cmd.last;
    end
    if (cmd_pop && cmd.last) begin
      sec_fill <= cmd.fill;
    end
  end

endmodule

FILE: hw/rtl/mpe_section_encapsulator.sv
// DVB multiprotocol encapsulation section builder, top level
// Input side: push/full, one datagram byte per transfer, with datagram_len
// sampled on the first byte of each datagram (clamped to 20..MAX_DATAGRAM).
// Output side: empty/pop, one section byte per transfer; section_end marks
// the last crc byte and fill_count gives the 0xff stuffing count there when
// stuff_enable is set (0 otherwise).
// Bytes 0 to 18 produce nothing; byte 19 releases a 32-byte burst (12 header
// bytes plus the 20 held bytes); later bytes pass through; the last byte is
// followed by 4 crc bytes. The output runs at one byte per cycle while the
// result queue has room, set by the single-byte crc/sequencer in the back
// end; input is taken at one byte per cycle while the 4-entry command queue
// has room, and full rises while the header burst drains. Each pass-through
// byte is held in the command queue, then the result queue, before its pop.
// When pop is held low the 2-entry result queue fills, the back end stops,
// then the command queue fills and full is raised; nothing is dropped.
// Reset (rst, synchronous) empties both queues, restarts the byte count and
// clears stuff_enable. Write stuff_enable only while the block is idle.
module mpe_section_encapsulator
  import mpe_pkg::*;
#(
  parameter int unsigned MAX_DATAGRAM = 4080
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic [11:0] datagram_len,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        section_end,
  output logic [7:0]  fill_count,
  input  logic        stuff_enable_we,
  input  logic        stuff_enable
);

  logic stuff_en_q;
  logic accept;
  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_full;
  logic cmd_empty;
  logic cmd_pop;
  res_t res_in;
  res_t res_head;
  logic res_full;
  logic res_push;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      stuff_en_q <= 1'b0;
    end else if (stuff_enable_we) begin
      stuff_en_q <= stuff_enable;
    end
  end

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // front end: byte count and classification
  mpe_front #(
    .MAX_DATAGRAM(MAX_DATAGRAM)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .datagram_len (datagram_len),
    .cmd          (cmd_in)
  );

  // command queue between front and back
  mpe_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .empty (cmd_empty)
  );

  // back end: header, pass-through and crc
  mpe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .stuff_enable (stuff_en_q),
    .cmd          (cmd_head),
    .cmd_empty    (cmd_empty),
    .cmd_pop      (cmd_pop),
    .res_full     (res_full),
    .res_push     (res_push),
    .res          (res_in)
  );

  // result queue toward the receiver
  mpe_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign out_byte    = res_head.out_byte;
  assign section_end = res_head.section_end;
  assign fill_count  = res_head.fill_count;

  // back end never writes a full result queue
  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(res_push && res_full))
    else $error("result written while result queue full");

  // back end only takes commands that are present
  a_cmd_no_underflow: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("command taken from empty queue");

  // a stuffing count shows only on the section end
  a_fill_on_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && (fill_count != 8'd0)) |-> section_end)
    else $error("fill count outside section end");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for the mpe_section_encapsulator top level
// depends on mpe_pkg and the rtl; drives the push/pop queues and checks every section byte
module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_DGRAM = 4080;
  localparam int LEAD_BYTES = 20;
  localparam int TS_PAYLOAD = 184;
  localparam int PHASE_BYTES = 50;

  // one expected section byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [7:0] fill;
  } sect_byte_t;

  // directed stimulus row, with the result count and end fill typed in
  typedef struct {
    logic [7:0]  data;
    logic [11:0] len;
    int          nres;
    int          fill;   // -1 where no section ends on this row
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic [11:0] datagram_len = 12'h000;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        section_end;
  logic [7:0]  fill_count;
  logic        stuff_enable_we = 1'b0;
  logic        stuff_enable = 1'b0;

  // predictor state
  int          sec_idx = 0;
  int          sec_len = 0;
  logic [7:0]  lead [LEAD_BYTES];
  logic [31:0] sec_crc = mpe_pkg::CRC_INIT;
  logic        stuff_on = 1'b0;
  sect_byte_t  section_q [$];

  int          send_idle = 0;
  int          recv_idle = 0;
  int          error_count = 0;
  int          bytes_sent = 0;
  int          sections_sent = 0;
  int          mcast_sent = 0;
  int          checked_bytes = 0;
  int          stall_cycles = 0;
  sect_byte_t  head_byte;
  dir_row_t    dir_rows [20];

  mpe_section_encapsulator u_top (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .data_byte       (data_byte),
    .datagram_len    (datagram_len),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .section_end     (section_end),
    .fill_count      (fill_count),
    .stuff_enable_we (stuff_enable_we),
    .stuff_enable    (stuff_enable)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // crc-32, msb first, one data bit at a time
  function automatic logic [31:0] crc_next(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      if (c[31] ^ b[i]) begin
        c = {c[30:0], 1'b0} ^ mpe_pkg::CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic void queue_section_byte(input logic [7:0] b, input logic last,
                                             input logic [7:0] fill);
    sect_byte_t e;
    e.data = b;
    e.last = last;
    e.fill = fill;
    section_q.push_back(e);
  endfunction

  // header and payload bytes also run through the crc
  function automatic void queue_covered_byte(input logic [7:0] b);
    sec_crc = crc_next(sec_crc, b);
    queue_section_byte(b, 1'b0, 8'h00);
  endfunction

  // predict the section bytes caused by one datagram byte; returns their count
  function automatic int encapsulate_byte(input logic [7:0] b, input logic [11:0] len_in);
    logic [11:0] slen;
    logic [7:0]  hdr [12];
    logic [7:0]  fill;
    int          n;
    n = 0;
    // first byte samples and clamps the length
    if (sec_idx == 0) begin
      sec_len = int'(len_in);
      if (sec_len < LEAD_BYTES) sec_len = LEAD_BYTES;
      if (sec_len > MAX_DGRAM) sec_len = MAX_DGRAM;
      sec_crc = mpe_pkg::CRC_INIT;
    end
    if (sec_idx < LEAD_BYTES) lead[sec_idx] = b;
    // header burst plus held bytes on the last lead byte
    if (sec_idx == LEAD_BYTES - 1) begin
      slen = 12'(sec_len) + mpe_pkg::SEC_OVERHEAD;
      hdr = '{default: 8'h00};
      hdr[0] = mpe_pkg::TABLE_ID;
      hdr[1] = mpe_pkg::SLEN_FLAGS | {4'h0, slen[11:8]};
      hdr[2] = slen[7:0];
      hdr[5] = mpe_pkg::HDR_FLAGS;
      if ((lead[16] & mpe_pkg::MCAST_MASK) == mpe_pkg::MCAST_MASK) begin
        hdr[3] = lead[19];
        hdr[4] = lead[18];
        hdr[8] = lead[17] & mpe_pkg::MAC3_MASK;
        hdr[9] = mpe_pkg::MAC2_MCAST;
        hdr[11] = mpe_pkg::MAC0_MCAST;
      end
      for (int k = 0; k < 12; k++) queue_covered_byte(hdr[k]);
      for (int k = 0; k < LEAD_BYTES; k++) queue_covered_byte(lead[k]);
      n = 32;
    end else if (sec_idx >= LEAD_BYTES) begin
      queue_covered_byte(b);
      n = 1;
    end
    // crc trailer and section boundary
    if (sec_idx + 1 >= sec_len) begin
      fill = stuff_on ? 8'((TS_PAYLOAD - 1) - ((sec_len + 16) % TS_PAYLOAD)) : 8'h00;
      queue_section_byte(sec_crc[31:24], 1'b0, 8'h00);
      queue_section_byte(sec_crc[23:16], 1'b0, 8'h00);
      queue_section_byte(sec_crc[15:8], 1'b0, 8'h00);
      queue_section_byte(sec_crc[7:0], 1'b1, fill);
      n += 4;
      sec_idx = 0;
      sec_crc = mpe_pkg::CRC_INIT;
    end else begin
      sec_idx++;
    end
    return n;
  endfunction

  // one input transfer, with random gaps in front
  task automatic send_byte(input logic [7:0] b, input logic [11:0] len_field, output int nres);
    if ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      data_byte <= 8'($urandom);
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    datagram_len <= len_field;
    @(posedge clk);
    while (full) @(posedge clk);
    nres = encapsulate_byte(b, len_field);
    bytes_sent++;
  endtask

  // random datagram; length sampled on byte 0 only
  task automatic send_datagram(input logic [11:0] len_field, input bit mcast);
    int          count;
    int          nres;
    logic [7:0]  b;
    logic [11:0] len_now;
    count = int'(len_field);
    if (count < LEAD_BYTES) count = LEAD_BYTES;
    if (count > MAX_DGRAM) count = MAX_DGRAM;
    for (int i = 0; i < count; i++) begin
      b = 8'($urandom);
      if (i == 16 && mcast) b = b | mpe_pkg::MCAST_MASK;
      len_now = (i == 0) ? len_field : 12'($urandom);
      send_byte(b, len_now, nres);
    end
    sections_sent++;
    if (mcast) mcast_sent++;
  endtask

  // stop sending and let every expected byte come out
  task automatic drain_block();
    push <= 1'b0;
    @(posedge clk);
    while (section_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_stuff(input logic v);
    stuff_enable_we <= 1'b1;
    stuff_enable <= v;
    @(posedge clk);
    stuff_enable_we <= 1'b0;
    stuff_on = v;
  endtask

  // receiver side pop pattern
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle);
  end

  // compare each output transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      checked_bytes++;
      if (section_q.size() == 0) begin
        $display("%0t: unexpected section byte, expected none, got %02h", $time, out_byte);
        error_count++;
      end else begin
        head_byte = section_q.pop_front();
        if (out_byte !== head_byte.data) begin
          $display("%0t: out_byte expected %02h got %02h", $time, head_byte.data, out_byte);
          error_count++;
        end
        if (section_end !== head_byte.last) begin
          $display("%0t: section_end expected %0b got %0b", $time, head_byte.last,
                   section_end);
          error_count++;
        end
        if (fill_count !== head_byte.fill) begin
          $display("%0t: fill_count expected %0d got %0d", $time, head_byte.fill,
                   fill_count);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d bytes still expected", $time,
               stall_cycles, section_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int          nres;
    int          pick;
    int          phase_start;
    logic [11:0] len_field;

    // minimum multicast datagram, length below range, extreme byte values
    dir_rows = '{
      '{8'h45, 12'h000, 0, -1}, '{8'h00, 12'hfff, 0, -1}, '{8'h00, 12'hfff, 0, -1},
      '{8'h14, 12'hfff, 0, -1}, '{8'hff, 12'hfff, 0, -1}, '{8'hff, 12'hfff, 0, -1},
      '{8'h00, 12'hfff, 0, -1}, '{8'h00, 12'hfff, 0, -1}, '{8'h40, 12'hfff, 0, -1},
      '{8'h11, 12'hfff, 0, -1}, '{8'h00, 12'hfff, 0, -1}, '{8'h00, 12'hfff, 0, -1},
      '{8'hc0, 12'hfff, 0, -1}, '{8'ha8, 12'hfff, 0, -1}, '{8'h01, 12'hfff, 0, -1},
      '{8'h01, 12'hfff, 0, -1}, '{8'he0, 12'hfff, 0, -1}, '{8'hff, 12'hfff, 0, -1},
      '{8'h00, 12'hfff, 0, -1}, '{8'haa, 12'hfff, 36, 147}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed section with stuffing on
    write_stuff(1'b1);
    for (int r = 0; r < 20; r++) begin
      send_byte(dir_rows[r].data, dir_rows[r].len, nres);
      if (nres != dir_rows[r].nres) begin
        $display("%0t: row %0d result count expected %0d got %0d", $time, r,
                 dir_rows[r].nres, nres);
        error_count++;
      end
      if (dir_rows[r].fill >= 0 && int'(section_q[$].fill) != dir_rows[r].fill) begin
        $display("%0t: row %0d fill expected %0d got %0d", $time, r, dir_rows[r].fill,
                 section_q[$].fill);
        error_count++;
      end
    end
    sections_sent++;
    mcast_sent++;
    drain_block();

    // random phases: slow receiver, slow sender, then no idling
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 16;
          recv_idle = 79;
        end
        1: begin
          send_idle = 79;
          recv_idle = 16;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      write_stuff(ph != 0);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          len_field = 12'($urandom_range(LEAD_BYTES - 1, 0));
        end else if (pick < 25) begin
          len_field = 12'(LEAD_BYTES);
        end else if (pick < 35) begin
          len_field = 12'(LEAD_BYTES + 1);
        end else begin
          len_field = 12'($urandom_range(64, LEAD_BYTES + 2));
        end
        send_datagram(len_field, 1'($urandom_range(1, 0)));
      end
      drain_block();
    end

    $display("covered %0d datagram bytes in %0d sections (%0d forced multicast),",
             bytes_sent, sections_sent, mcast_sent);
    $display("stuffing on and off, both sides stalling; %0d section bytes checked",
             checked_bytes);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/mpe_pkg.sv
hw/rtl/mpe_fifo.sv
hw/rtl/mpe_front.sv
hw/rtl/mpe_back.sv
hw/rtl/mpe_section_encapsulator.sv
sim/tb_top.sv
